@@ rtl/ptns_pkg.sv @@
// ----------------------------------------------------------------------------
// ptns_pkg
// Shared types, sizes and codes for the point table nearest search block.
// ----------------------------------------------------------------------------
package ptns_pkg;

  // Table geometry
  localparam int DEPTH      = 64;
  localparam int COORD_BITS = 10;
  localparam int IDX_W      = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W      = $clog2(DEPTH + 1);

  // Field widths
  localparam int ID_W   = 32;
  localparam int KIND_W = 16;
  localparam int LIM_W  = COORD_BITS + 1;
  localparam int OP_W   = 3;
  localparam int STAT_W = 2;

  // Stream packing: first field in the lowest bits, padded to whole bytes
  localparam int IN_ID_LSB   = 0;
  localparam int IN_KIND_LSB = IN_ID_LSB + ID_W;
  localparam int IN_X_LSB    = IN_KIND_LSB + KIND_W;
  localparam int IN_Y_LSB    = IN_X_LSB + COORD_BITS;
  localparam int IN_LIM_LSB  = IN_Y_LSB + COORD_BITS;
  localparam int IN_BITS     = IN_LIM_LSB + LIM_W;
  localparam int IN_W        = ((IN_BITS + 7) / 8) * 8;
  localparam int OUT_BITS    = ID_W + KIND_W + 3 * COORD_BITS;
  localparam int OUT_W       = ((OUT_BITS + 7) / 8) * 8;

  // Request codes
  typedef enum logic [OP_W-1:0] {
    OP_APPEND  = 3'd0,
    OP_REMOVE  = 3'd1,
    OP_CLEAR   = 3'd2,
    OP_FIND_ID = 3'd3,
    OP_FIND_XY = 3'd4,
    OP_NEAREST = 3'd5
  } op_t;

  // Result codes
  typedef enum logic [STAT_W-1:0] {
    ST_OK        = 2'd0,
    ST_NOT_FOUND = 2'd1,
    ST_FULL      = 2'd2
  } status_t;

  // Sequencer states
  typedef enum logic [2:0] {
    S_IDLE,
    S_DECODE,
    S_SCAN,
    S_SHIFT,
    S_RESULT
  } state_t;

  // One stored table entry
  typedef struct packed {
    logic [ID_W-1:0]       id;
    logic [KIND_W-1:0]     kind;
    logic [COORD_BITS-1:0] x;
    logic [COORD_BITS-1:0] y;
  } entry_t;

  // One latched request
  typedef struct packed {
    op_t                   op;
    logic [ID_W-1:0]       id;
    logic [KIND_W-1:0]     kind;
    logic [COORD_BITS-1:0] x;
    logic [COORD_BITS-1:0] y;
    logic [LIM_W-1:0]      limit;
  } req_t;

  // Table write port bundle
  typedef struct packed {
    logic             en;
    logic [IDX_W-1:0] addr;
    entry_t           data;
  } wr_t;

  // Compare unit verdict
  typedef struct packed {
    logic                  take;
    logic [COORD_BITS-1:0] distance;
  } cmp_t;

endpackage

@@ rtl/ptns_store.sv @@
// ----------------------------------------------------------------------------
// ptns_store
// Entry table memory: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module ptns_store (
  input  logic                           clk,
  input  ptns_pkg::wr_t                  wr,
  input  logic                           rd_en,
  input  logic [ptns_pkg::IDX_W-1:0]     rd_addr,
  output ptns_pkg::entry_t               rd_data
);
  import ptns_pkg::*;

  entry_t mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

@@ rtl/ptns_cmp.sv @@
// ----------------------------------------------------------------------------
// ptns_cmp
// Shared compare unit: judges one table entry against the current request.
// ----------------------------------------------------------------------------
module ptns_cmp (
  input  ptns_pkg::req_t                  req,
  input  ptns_pkg::entry_t                entry,
  input  logic                            hit,
  input  logic [ptns_pkg::COORD_BITS-1:0] best,
  output ptns_pkg::cmp_t                  res
);
  import ptns_pkg::*;

  logic [COORD_BITS-1:0] dx;
  logic [COORD_BITS-1:0] dy;
  logic [COORD_BITS-1:0] cheb;

  // Chebyshev distance max(|dx|, |dy|)
  always_comb begin
    dx   = (entry.x > req.x) ? (entry.x - req.x) : (req.x - entry.x);
    dy   = (entry.y > req.y) ? (entry.y - req.y) : (req.y - entry.y);
    cheb = (dx > dy) ? dx : dy;
  end

  // Match rule per request; first match wins, ties keep the earlier entry
  always_comb begin
    res.distance = cheb;
    unique case (req.op)
      OP_REMOVE, OP_FIND_ID: res.take = !hit && (entry.id == req.id);
      OP_FIND_XY:            res.take = !hit && (entry.x == req.x) && (entry.y == req.y);
      OP_NEAREST:            res.take = ({1'b0, cheb} < req.limit) && (!hit || cheb < best);
      default:               res.take = 1'b0;
    endcase
  end

endmodule

@@ rtl/point_table_nearest_search.sv @@
// ----------------------------------------------------------------------------
// point_table_nearest_search
// Ordered entry table with append, remove, clear, find by id, find by
// coordinates and nearest search by Chebyshev distance.
// ----------------------------------------------------------------------------
//
//  Channel   Direction  Content
//  s_axis    in         tuser: opcode; tdata: entry_id, kind_code, pos_x,
//                       pos_y, distance_limit
//  m_axis    out        tuser: status; tdata: found_id, found_kind, found_x,
//                       found_y, found_distance
//
//  Append, clear, unused codes: decode, then result; no table scan.
//  Searches: decode, a scan of the n stored entries, then result; one
//  entry per cycle through the shared compare unit.
//  A remove that hits entry k then moves entries k+1 to n-1 down by one.
//  Reset clears the entry count and control; the table needs no clearing.
//  A result waits in the output register; the next transaction is accepted
//  meanwhile, and its own result waits until the register is free.
//
module point_table_nearest_search (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  // [31:0] entry_id, [47:32] kind_code, [57:48] pos_x, [67:58] pos_y,
  // [78:68] distance_limit, rest zero
  input  logic [ptns_pkg::IN_W-1:0]     s_axis_tdata,
  // [2:0] opcode
  input  logic [ptns_pkg::OP_W-1:0]     s_axis_tuser,
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // [31:0] found_id, [47:32] found_kind, [57:48] found_x, [67:58] found_y,
  // [77:68] found_distance, rest zero
  output logic [ptns_pkg::OUT_W-1:0]    m_axis_tdata,
  // [1:0] status
  output logic [ptns_pkg::STAT_W-1:0]   m_axis_tuser
);
  import ptns_pkg::*;

  state_t                state;
  state_t                state_next;
  req_t                  req;
  logic [CNT_W-1:0]      entry_count;
  logic [CNT_W-1:0]      scan_idx;
  logic                  rv;
  logic [IDX_W-1:0]      ridx;
  logic                  hit;
  logic [IDX_W-1:0]      hit_idx;
  entry_t                found;
  logic [COORD_BITS-1:0] best;
  status_t               res_status;
  logic [OUT_W-1:0]      out_data;
  status_t               out_status;
  logic                  out_valid;

  wr_t                   wr;
  logic                  rd_en;
  logic [IDX_W-1:0]      rd_addr;
  entry_t                rd_data;
  cmp_t                  cmp;
  logic                  scan_more;
  logic                  phase_end;
  logic                  full;
  logic                  out_load;

  ptns_store u_store (
    .clk     (clk),
    .wr      (wr),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  ptns_cmp u_cmp (
    .req   (req),
    .entry (rd_data),
    .hit   (hit),
    .best  (best),
    .res   (cmp)
  );

  assign s_axis_tready = (state == S_IDLE);
  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = out_data;
  assign m_axis_tuser  = out_status;

  assign scan_more = (scan_idx < entry_count);
  assign phase_end = !scan_more && !rv;
  assign full      = (entry_count >= CNT_W'(DEPTH));
  assign out_load  = (state == S_RESULT) && (!out_valid || m_axis_tready);

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state and table port control
  always_comb begin
    state_next = state;
    wr         = '0;
    rd_en      = 1'b0;
    rd_addr    = scan_idx[IDX_W-1:0];
    unique case (state)
      S_IDLE: begin
        if (s_axis_tvalid) state_next = S_DECODE;
      end
      S_DECODE: begin
        case (req.op) inside
          OP_APPEND: begin
            wr.en      = !full;
            wr.addr    = entry_count[IDX_W-1:0];
            wr.data.id = req.id;
            wr.data.kind = req.kind;
            wr.data.x  = req.x;
            wr.data.y  = req.y;
            state_next = S_RESULT;
          end
          OP_REMOVE, OP_FIND_ID, OP_FIND_XY, OP_NEAREST: state_next = S_SCAN;
          default: state_next = S_RESULT;
        endcase
      end
      S_SCAN: begin
        rd_en = scan_more;
        if (phase_end) begin
          state_next = (req.op == OP_REMOVE && hit) ? S_SHIFT : S_RESULT;
        end
      end
      S_SHIFT: begin
        // read entry j while writing entry j-1 (the previous read) into slot j-2
        rd_en   = scan_more;
        wr.en   = rv;
        wr.addr = ridx - 1'b1;
        wr.data = rd_data;
        if (phase_end) state_next = S_RESULT;
      end
      S_RESULT: begin
        if (!out_valid || m_axis_tready) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      entry_count <= '0;
      scan_idx    <= '0;
      rv          <= 1'b0;
      hit         <= 1'b0;
      out_valid   <= 1'b0;
    end else begin
      rv <= rd_en;
      if (rd_en) scan_idx <= scan_idx + 1'b1;
      unique case (state)
        S_DECODE: begin
          hit      <= 1'b0;
          scan_idx <= '0;
          if (req.op == OP_APPEND && !full) entry_count <= entry_count + 1'b1;
          if (req.op == OP_CLEAR) entry_count <= '0;
        end
        S_SCAN: begin
          if (rv && cmp.take) hit <= 1'b1;
          if (phase_end) scan_idx <= CNT_W'(hit_idx) + 1'b1;
        end
        S_SHIFT: begin
          if (phase_end) entry_count <= entry_count - 1'b1;
        end
        default: ;
      endcase
      // output register: refilled at result time, else drained by the sink
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    ridx <= rd_addr;
    if (s_axis_tvalid && s_axis_tready) begin
      req.op    <= op_t'(s_axis_tuser);
      req.id    <= s_axis_tdata[IN_ID_LSB +: ID_W];
      req.kind  <= s_axis_tdata[IN_KIND_LSB +: KIND_W];
      req.x     <= s_axis_tdata[IN_X_LSB +: COORD_BITS];
      req.y     <= s_axis_tdata[IN_Y_LSB +: COORD_BITS];
      req.limit <= s_axis_tdata[IN_LIM_LSB +: LIM_W];
    end
    unique case (state)
      S_DECODE: begin
        found <= '0;
        best  <= '0;
        if (req.op == OP_APPEND) begin
          res_status <= full ? ST_FULL : ST_OK;
        end else if (req.op == OP_CLEAR) begin
          res_status <= ST_OK;
        end else begin
          res_status <= ST_NOT_FOUND;
        end
      end
      S_SCAN: begin
        if (rv && cmp.take) begin
          hit_idx <= ridx;
          found   <= rd_data;
          best    <= cmp.distance;
        end
        if (phase_end) res_status <= hit ? ST_OK : ST_NOT_FOUND;
      end
      default: ;
    endcase
    if (out_load) begin
      out_status <= res_status;
      out_data   <= OUT_W'({(req.op == OP_NEAREST) ? best : {COORD_BITS{1'b0}},
                            found.y, found.x, found.kind, found.id});
    end
  end

  // Assertions
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("request accepted while a request is in progress");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    entry_count <= CNT_W'(DEPTH))
    else $error("entry count above table depth");

  a_write_origin: assert property (@(posedge clk) disable iff (rst)
    wr.en |-> (state == S_DECODE && req.op == OP_APPEND && !full) || state == S_SHIFT)
    else $error("table write outside append or shift");

  a_read_in_range: assert property (@(posedge clk) disable iff (rst)
    rd_en |-> (scan_idx < entry_count))
    else $error("table read beyond stored entries");

  a_remove_shrinks: assert property (@(posedge clk) disable iff (rst)
    state == S_SHIFT && phase_end |=> entry_count == $past(entry_count) - CNT_W'(1))
    else $error("remove did not shrink the table by one");

endmodule

@@ test/point_table_nearest_search_tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// point_table_nearest_search_tb
// Stream-level test of the point table: a short scripted sequence over the
// empty, corner and tie cases, then random episodes (table fills, mixed
// traffic on stored ids and points, noise) with idle gaps and back-pressure
// on both sides. Each result is checked against an in-order table model.
// ----------------------------------------------------------------------------
module point_table_nearest_search_tb;
  import ptns_pkg::*;

  localparam int CLK_HALF     = 6;
  localparam int RESET_CYCLES = 4;
  localparam int RANDOM_ITEMS = 1500;
  // Slowest item is a remove that scans and then shifts the whole table, plus
  // the longest gap on each side and the long hold-off; several times that.
  localparam int IDLE_LIMIT   = 3000;
  localparam int HOLD_CYCLES  = 400;
  localparam int HOLD_AFTER   = 300;
  localparam int DRAIN_CYCLES = 20;
  localparam int MAX_REPORTS  = 200;

  // Opcodes with no function; the block answers not found
  localparam logic [OP_W-1:0] OP_SPARE_6 = 3'd6;
  localparam logic [OP_W-1:0] OP_SPARE_7 = 3'd7;

  typedef struct packed {
    logic [OP_W-1:0]       code;
    logic [ID_W-1:0]       id;
    logic [KIND_W-1:0]     kind;
    logic [COORD_BITS-1:0] x;
    logic [COORD_BITS-1:0] y;
    logic [LIM_W-1:0]      limit;
  } request_t;

  typedef struct packed {
    logic [STAT_W-1:0]     status;
    logic [ID_W-1:0]       id;
    logic [KIND_W-1:0]     kind;
    logic [COORD_BITS-1:0] x;
    logic [COORD_BITS-1:0] y;
    logic [COORD_BITS-1:0] distance;
  } answer_t;

  typedef struct packed {
    request_t req;
    logic     fixed;
    answer_t  want;
  } script_row_t;

  typedef enum int {EP_FILL, EP_MIXED, EP_NOISE} episode_t;

  logic              clk           = 1'b0;
  logic              rst           = 1'b1;
  logic              s_axis_tvalid = 1'b0;
  logic              s_axis_tready;
  logic [IN_W-1:0]   s_axis_tdata  = '0;
  logic [OP_W-1:0]   s_axis_tuser  = '0;
  logic              m_axis_tvalid;
  logic              m_axis_tready = 1'b0;
  logic [OUT_W-1:0]  m_axis_tdata;
  logic [STAT_W-1:0] m_axis_tuser;

  // Table model state
  entry_t stored [DEPTH];
  int     stored_count = 0;

  answer_t expected_answers [$];
  int      error_count  = 0;
  int      report_count = 0;
  int      items_sent   = 0;
  int      results_seen = 0;
  int      idle_cycles  = 0;
  bit      hold_active  = 1'b0;
  bit      burst_mode   = 1'b0;
  bit      clustered    = 1'b0;
  int      cluster_x    = 0;
  int      cluster_y    = 0;

  always #(CLK_HALF) clk = ~clk;

  point_table_nearest_search u_top (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  // Copy a table entry into a found result
  function automatic answer_t report_entry(answer_t a, entry_t e);
    a.status = ST_OK;
    a.id     = e.id;
    a.kind   = e.kind;
    a.x      = e.x;
    a.y      = e.y;
    return a;
  endfunction

  // Apply one request to the table model and return its result
  function automatic answer_t run_table_request(request_t r);
    answer_t a;
    int      hit;
    int      best;
    int      d;
    int      dx;
    int      dy;
    int      n;
    a        = '0;
    a.status = ST_NOT_FOUND;
    hit      = -1;
    best     = 0;
    n        = stored_count;
    case (r.code)
      OP_APPEND: begin
        if (n >= DEPTH) begin
          a.status = ST_FULL;
        end else begin
          stored[n].id   = r.id;
          stored[n].kind = r.kind;
          stored[n].x    = r.x;
          stored[n].y    = r.y;
          stored_count   = n + 1;
          a.status       = ST_OK;
        end
      end
      OP_REMOVE: begin
        for (int k = 0; k < n && hit < 0; k++)
          if (stored[k].id == r.id) hit = k;
        if (hit >= 0) begin
          a = report_entry(a, stored[hit]);
          for (int k = hit; k + 1 < n; k++) stored[k] = stored[k + 1];
          stored_count = n - 1;
        end
      end
      OP_CLEAR: begin
        stored_count = 0;
        a.status     = ST_OK;
      end
      OP_FIND_ID: begin
        for (int k = 0; k < n && hit < 0; k++)
          if (stored[k].id == r.id) hit = k;
        if (hit >= 0) a = report_entry(a, stored[hit]);
      end
      OP_FIND_XY: begin
        for (int k = 0; k < n && hit < 0; k++)
          if (stored[k].x == r.x && stored[k].y == r.y) hit = k;
        if (hit >= 0) a = report_entry(a, stored[hit]);
      end
      OP_NEAREST: begin
        // Chebyshev distance, strict bound, earlier entry wins a tie
        for (int k = 0; k < n; k++) begin
          dx = (stored[k].x > r.x) ? stored[k].x - r.x : r.x - stored[k].x;
          dy = (stored[k].y > r.y) ? stored[k].y - r.y : r.y - stored[k].y;
          d  = (dx > dy) ? dx : dy;
          if (d < int'(r.limit) && (hit < 0 || d < best)) begin
            hit  = k;
            best = d;
          end
        end
        if (hit >= 0) begin
          a          = report_entry(a, stored[hit]);
          a.distance = best[COORD_BITS-1:0];
        end
      end
      default: ;
    endcase
    return a;
  endfunction

  function automatic logic [IN_W-1:0] pack_request(request_t r);
    logic [IN_W-1:0] v;
    v = '0;
    v[IN_ID_LSB   +: ID_W]       = r.id;
    v[IN_KIND_LSB +: KIND_W]     = r.kind;
    v[IN_X_LSB    +: COORD_BITS] = r.x;
    v[IN_Y_LSB    +: COORD_BITS] = r.y;
    v[IN_LIM_LSB  +: LIM_W]      = r.limit;
    return v;
  endfunction

  function automatic script_row_t mk(logic [OP_W-1:0] code, logic [ID_W-1:0] id,
                                     logic [KIND_W-1:0] kind, int x, int y, int lim);
    script_row_t row;
    row           = '0;
    row.req.code  = code;
    row.req.id    = id;
    row.req.kind  = kind;
    row.req.x     = COORD_BITS'(x);
    row.req.y     = COORD_BITS'(y);
    row.req.limit = LIM_W'(lim);
    return row;
  endfunction

  function automatic script_row_t mk_fixed(logic [OP_W-1:0] code, logic [ID_W-1:0] id,
                                           logic [KIND_W-1:0] kind, int x, int y, int lim,
                                           logic [STAT_W-1:0] st, logic [ID_W-1:0] fid,
                                           logic [KIND_W-1:0] fkind, int fx, int fy,
                                           int fd);
    script_row_t row;
    row                 = mk(code, id, kind, x, y, lim);
    row.fixed           = 1'b1;
    row.want.status     = st;
    row.want.id         = fid;
    row.want.kind       = fkind;
    row.want.x          = COORD_BITS'(fx);
    row.want.y          = COORD_BITS'(fy);
    row.want.distance   = COORD_BITS'(fd);
    return row;
  endfunction

  // Idle length: mostly none or short, now and then long
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 15);
    return $urandom_range(20, 80);
  endfunction

  function automatic int nudge(int v);
    int t;
    t = v + $urandom_range(0, 8) - 4;
    if (t < 0) t = 0;
    if (t > 1023) t = 1023;
    return t;
  endfunction

  // Random request; most searches and removes aim at stored entries
  function automatic request_t pick_request(episode_t ep);
    request_t r;
    entry_t   e;
    int       sel;
    bit       aim;
    sel = $urandom_range(0, 99);
    case (ep)
      EP_FILL:  r.code = (sel < 85) ? OP_APPEND : (sel < 90) ? OP_FIND_ID :
                         (sel < 95) ? OP_NEAREST : OP_FIND_XY;
      EP_NOISE: r.code = OP_W'($urandom_range(0, 7));
      default: begin
        if (sel < 28)      r.code = OP_APPEND;
        else if (sel < 44) r.code = OP_REMOVE;
        else if (sel < 46) r.code = OP_CLEAR;
        else if (sel < 62) r.code = OP_FIND_ID;
        else if (sel < 78) r.code = OP_FIND_XY;
        else               r.code = OP_NEAREST;
      end
    endcase
    r.id   = ($urandom_range(0, 19) == 0) ? {ID_W{1'b1}} : $urandom();
    r.kind = KIND_W'($urandom_range(0, 65535));
    if (clustered) begin
      r.x = COORD_BITS'(cluster_x + $urandom_range(0, 7));
      r.y = COORD_BITS'(cluster_y + $urandom_range(0, 7));
    end else begin
      r.x = COORD_BITS'($urandom_range(0, 1023));
      r.y = COORD_BITS'($urandom_range(0, 1023));
    end
    sel = $urandom_range(0, 9);
    if (sel == 0)     r.limit = '0;
    else if (sel < 3) r.limit = LIM_W'(1024);
    else if (sel < 6) r.limit = LIM_W'($urandom_range(1, 16));
    else              r.limit = LIM_W'($urandom_range(0, 1024));

    aim = ep != EP_NOISE && stored_count > 0 && $urandom_range(0, 9) < 7;
    if (aim) begin
      e = stored[$urandom_range(0, stored_count - 1)];
      case (r.code)
        OP_REMOVE, OP_FIND_ID: r.id = e.id;
        OP_APPEND:  if ($urandom_range(0, 9) < 3) r.id = e.id;
        OP_FIND_XY: begin
          r.x = e.x;
          r.y = e.y;
        end
        OP_NEAREST: begin
          r.x = COORD_BITS'(nudge(e.x));
          r.y = COORD_BITS'(nudge(e.y));
        end
        default: ;
      endcase
    end
    return r;
  endfunction

  // Offer one transaction; predict its result once it is accepted
  task automatic offer(request_t r, logic fixed, answer_t want);
    answer_t predicted;
    int      gap;
    gap = (hold_active || burst_mode) ? 0 : pick_gap();
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= pack_request(r);
    s_axis_tuser  <= r.code;
    do @(posedge clk); while (!s_axis_tready);
    predicted = run_table_request(r);
    expected_answers = {expected_answers, (fixed ? want : predicted)};
    items_sent++;
  endtask

  // Stimulus: scripted cases, then random episodes
  initial begin : stimulus
    script_row_t rows [$];
    answer_t     none;
    episode_t    ep;
    int          len;
    int          sel;
    int          target;
    none = '0;

    // Empty table and spare opcodes
    rows = {rows, mk_fixed(OP_FIND_ID, 0, 0, 0, 0, 0, ST_NOT_FOUND, 0, 0, 0, 0, 0)};
    rows = {rows, mk_fixed(OP_NEAREST, 0, 0, 0, 0, 1024, ST_NOT_FOUND, 0, 0, 0, 0, 0)};
    rows = {rows, mk_fixed(OP_REMOVE, 0, 0, 0, 0, 0, ST_NOT_FOUND, 0, 0, 0, 0, 0)};
    rows = {rows, mk_fixed(OP_FIND_XY, 0, 0, 0, 0, 0, ST_NOT_FOUND, 0, 0, 0, 0, 0)};
    rows = {rows, mk_fixed(OP_SPARE_6, '1, '1, 1023, 1023, 1024,
                           ST_NOT_FOUND, 0, 0, 0, 0, 0)};
    rows = {rows, mk_fixed(OP_SPARE_7, '1, '1, 1023, 1023, 1024,
                           ST_NOT_FOUND, 0, 0, 0, 0, 0)};
    // Corner entries
    rows = {rows, mk_fixed(OP_APPEND, 0, 0, 0, 0, 0, ST_OK, 0, 0, 0, 0, 0)};
    rows = {rows, mk_fixed(OP_APPEND, '1, '1, 1023, 1023, 1024, ST_OK, 0, 0, 0, 0, 0)};
    rows = {rows, mk_fixed(OP_APPEND, 5, 16'h1234, 512, 300, 0, ST_OK, 0, 0, 0, 0, 0)};
    rows = {rows, mk_fixed(OP_FIND_ID, '1, 0, 0, 0, 0, ST_OK, '1, '1, 1023, 1023, 0)};
    rows = {rows, mk_fixed(OP_FIND_XY, 0, 0, 0, 0, 0, ST_OK, 0, 0, 0, 0, 0)};
    rows = {rows, mk_fixed(OP_FIND_XY, 0, 0, 1023, 0, 0, ST_NOT_FOUND, 0, 0, 0, 0, 0)};
    rows = {rows, mk_fixed(OP_NEAREST, 0, 0, 1023, 1023, 1024,
                           ST_OK, '1, '1, 1023, 1023, 0)};
    rows = {rows, mk(OP_NEAREST, 0, 0, 0, 1023, 1024)};
    // Zero limit never matches; limit just at and just above the distance
    rows = {rows, mk_fixed(OP_NEAREST, 0, 0, 512, 300, 0, ST_NOT_FOUND, 0, 0, 0, 0, 0)};
    rows = {rows, mk(OP_NEAREST, 0, 0, 513, 301, 1)};
    rows = {rows, mk(OP_NEAREST, 0, 0, 513, 301, 2)};
    // Duplicate id: remove takes the first, the second stays findable
    rows = {rows, mk(OP_APPEND, 5, 7, 10, 10, 0)};
    rows = {rows, mk(OP_REMOVE, 5, 0, 0, 0, 0)};
    rows = {rows, mk(OP_FIND_ID, 5, 0, 0, 0, 0)};
    // Equal distance to two entries: the earlier one wins
    rows = {rows, mk(OP_APPEND, 9, 3, 20, 10, 0)};
    rows = {rows, mk(OP_NEAREST, 0, 0, 15, 10, 1024)};
    // Clear empties the table
    rows = {rows, mk_fixed(OP_CLEAR, 0, 0, 0, 0, 0, ST_OK, 0, 0, 0, 0, 0)};
    rows = {rows, mk_fixed(OP_FIND_ID, '1, 0, 0, 0, 0, ST_NOT_FOUND, 0, 0, 0, 0, 0)};
    rows = {rows, mk_fixed(OP_NEAREST, 0, 0, 0, 0, 1024, ST_NOT_FOUND, 0, 0, 0, 0, 0)};

    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;

    foreach (rows[i]) offer(rows[i].req, rows[i].fixed, rows[i].want);

    // Random episodes; the first one fills the table
    target = items_sent + RANDOM_ITEMS;
    ep     = EP_FILL;
    while (items_sent < target) begin
      burst_mode = ($urandom_range(0, 4) == 0);
      clustered  = ($urandom_range(0, 2) == 0);
      sel        = $urandom_range(0, 2);
      cluster_x  = (sel == 0) ? 0 : (sel == 1) ? 1016 : $urandom_range(0, 1016);
      sel        = $urandom_range(0, 2);
      cluster_y  = (sel == 0) ? 0 : (sel == 1) ? 1016 : $urandom_range(0, 1016);
      if (ep == EP_FILL) begin
        while (stored_count < DEPTH) offer(pick_request(EP_FILL), 1'b0, none);
        len = $urandom_range(2, 6);
      end else begin
        len = $urandom_range(20, 60);
      end
      repeat (len) offer(pick_request(ep), 1'b0, none);
      sel = $urandom_range(0, 9);
      ep  = (sel == 0) ? EP_FILL : (sel == 9) ? EP_NOISE : EP_MIXED;
    end
    s_axis_tvalid <= 1'b0;

    while (expected_answers.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (error_count == 0) begin
      $display("point_table_nearest_search verification clean");
    end else begin
      $display("point_table_nearest_search verification failed");
    end
    $finish;
  end

  // Result side ready: random runs and stalls, one long hold-off
  initial begin : result_ready
    int run;
    int stall;
    bit held;
    held = 1'b0;
    repeat (RESET_CYCLES) @(posedge clk);
    forever begin
      if (!held && results_seen >= HOLD_AFTER) begin
        held          = 1'b1;
        hold_active   = 1'b1;
        m_axis_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_active   = 1'b0;
      end
      m_axis_tready <= 1'b1;
      run = $urandom_range(0, 99);
      run = (run < 60) ? $urandom_range(1, 4) :
            (run < 90) ? $urandom_range(5, 30) : $urandom_range(50, 200);
      repeat (run) @(posedge clk);
      stall = pick_gap();
      if (stall > 0) begin
        m_axis_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
    end
  end

  // Compare each result transaction with the oldest prediction
  always @(posedge clk) begin : result_check
    answer_t want;
    answer_t got;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      results_seen++;
      // Output fields share the input layout; distance sits where the limit does
      got.status   = m_axis_tuser;
      got.id       = m_axis_tdata[IN_ID_LSB   +: ID_W];
      got.kind     = m_axis_tdata[IN_KIND_LSB +: KIND_W];
      got.x        = m_axis_tdata[IN_X_LSB    +: COORD_BITS];
      got.y        = m_axis_tdata[IN_Y_LSB    +: COORD_BITS];
      got.distance = m_axis_tdata[IN_LIM_LSB  +: COORD_BITS];
      if (expected_answers.size() == 0) begin
        error_count++;
        if (report_count++ < MAX_REPORTS)
          $display("%0t: result with none expected: st=%0d id=%h kind=%h x=%0d y=%0d d=%0d",
                   $time, got.status, got.id, got.kind, got.x, got.y, got.distance);
      end else begin
        want = expected_answers.pop_front();
        if (got.status !== want.status || got.id !== want.id || got.kind !== want.kind ||
            got.x !== want.x || got.y !== want.y || got.distance !== want.distance) begin
          error_count++;
          if (report_count++ < MAX_REPORTS) begin
            $display("%0t: result %0d mismatch", $time, results_seen);
            $display("  expected st=%0d id=%h kind=%h x=%0d y=%0d d=%0d",
                     want.status, want.id, want.kind, want.x, want.y, want.distance);
            $display("  actual   st=%0d id=%h kind=%h x=%0d y=%0d d=%0d",
                     got.status, got.id, got.kind, got.x, got.y, got.distance);
          end
        end
      end
    end
  end

  // Watchdog: no transaction on either side for too long
  always @(posedge clk) begin
    if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("%0t: no transaction for %0d cycles, %0d results outstanding",
               $time, idle_cycles, expected_answers.size());
      $display("point_table_nearest_search verification failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

endmodule
